// File: design/ledscan_pkg.sv
// Types, constants, font ROM and microprogram for the LED panel scan driver.
package ledscan_pkg;

    localparam int FRAME_BYTES = 64;
    localparam int FRAME_AW    = 6;
    localparam int GLYPH_BYTES = 12;
    localparam int FONT_DIGITS = 10;
    localparam int FONT_AW     = 7;

    localparam logic [15:0] HOLD_RESET = 16'd25;
    localparam logic [5:0]  BLINK_BASE = 6'd30;
    localparam logic [3:0]  DIGIT_MAX  = 4'd9;

    // request codes
    localparam logic [1:0] REQ_DIGIT = 2'd0;
    localparam logic [1:0] REQ_BLINK = 2'd1;
    localparam logic [1:0] REQ_SCAN  = 2'd2;

    // register word index
    localparam logic REG_HOLD_TICKS = 1'b0;

    // pin_levels bit positions
    localparam int PIN_CLK = 0;
    localparam int PIN_DAT = 1;
    localparam int PIN_STB = 2;
    localparam int PIN_MOD = 3;

    typedef enum logic [2:0] {
        PH_BANK  = 3'd0,
        PH_PIX   = 3'd1,
        PH_HOLD  = 3'd2,
        PH_ROW   = 3'd3,
        PH_LATCH = 3'd4
    } phase_t;

    // micro-PC
    typedef enum logic [1:0] {
        UPC_IDLE      = 2'd0,
        UPC_WR_GLYPH  = 2'd1,
        UPC_WR_COLON  = 2'd2,
        UPC_SCAN_EMIT = 2'd3
    } upc_t;

    typedef struct packed {
        logic       wr_en;     // write a byte into the frame store
        logic       wr_colon;  // source is the colon pattern, else font ROM
        logic       emit;      // advance the scan and present pins
        logic [3:0] cnt_last;  // loop count at which the step returns to idle
    } ucode_t;

    localparam ucode_t UCODE [4] = '{
        '{wr_en: 1'b0, wr_colon: 1'b0, emit: 1'b0, cnt_last: 4'd0},
        '{wr_en: 1'b1, wr_colon: 1'b0, emit: 1'b0, cnt_last: 4'd11},
        '{wr_en: 1'b1, wr_colon: 1'b1, emit: 1'b0, cnt_last: 4'd3},
        '{wr_en: 1'b0, wr_colon: 1'b0, emit: 1'b1, cnt_last: 4'd0}
    };

    localparam logic [7:0] COLON_PATTERN [4] = '{8'h03, 8'h60, 8'h03, 8'h60};
    localparam logic [5:0] PLACE_BASE [4]    = '{6'd2, 6'd16, 6'd38, 6'd52};

    localparam logic [7:0] FONT_ROM [FONT_DIGITS * GLYPH_BYTES] = '{
        8'h03,8'he0,8'h05,8'h10,8'h04,8'h90,8'h04,8'h50,8'h03,8'he0,8'h00,8'h00,
        8'h00,8'h00,8'h04,8'h20,8'h07,8'hf0,8'h04,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h06,8'h20,8'h05,8'h10,8'h04,8'h90,8'h04,8'h90,8'h04,8'h60,8'h00,8'h00,
        8'h02,8'h20,8'h04,8'h10,8'h04,8'h90,8'h04,8'h90,8'h03,8'h60,8'h00,8'h00,
        8'h01,8'h80,8'h01,8'h40,8'h01,8'h20,8'h07,8'hf0,8'h01,8'h00,8'h00,8'h00,
        8'h02,8'h70,8'h04,8'h50,8'h04,8'h50,8'h04,8'h50,8'h03,8'h90,8'h00,8'h00,
        8'h03,8'hc0,8'h04,8'ha0,8'h04,8'h90,8'h04,8'h90,8'h03,8'h00,8'h00,8'h00,
        8'h00,8'h10,8'h07,8'h10,8'h00,8'h90,8'h00,8'h50,8'h00,8'h30,8'h00,8'h00,
        8'h03,8'h60,8'h04,8'h90,8'h04,8'h90,8'h04,8'h90,8'h03,8'h60,8'h00,8'h00,
        8'h00,8'h60,8'h04,8'h90,8'h04,8'h90,8'h02,8'h90,8'h01,8'he0,8'h00,8'h00
    };

endpackage

// File: design/led_panel_scan_driver.sv
// Top level of the LED panel scan driver: microcoded sequencer, frame store, scan engine.
//
//  channel   direction  handshake                 payload
//  request   in         in_valid / in_ready       req_type, digit_value, digit_position,
//                                                 blinker_on
//  pins      out        out_valid / out_ready     pin_clock, pin_data, pin_strobe, pin_mode
//  config    in         APB psel/penable/pready   hold_ticks at byte address 0
//
//  Items are accepted while idle. A scan tick then emits once the pin register
//  is free, a digit draw writes once per glyph byte, a blinker draw once per colon
//  byte; ignored requests stay idle. The single frame store write port sets the
//  draw cost. Frame store reads are zero until written: a valid bit per byte is
//  cleared by reset, so no clearing pass is run. Reset state drives all pins high.
module led_panel_scan_driver #(
    parameter int ROWS = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [3:0]  digit_value,
    input  logic [1:0]  digit_position,
    input  logic        blinker_on,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        pin_clock,
    output logic        pin_data,
    output logic        pin_strobe,
    output logic        pin_mode,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------- config
    logic [15:0] hold_ticks_reg;
    logic        cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == ledscan_pkg::REG_HOLD_TICKS);
    assign prdata  = cfg_hit ? {16'd0, hold_ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= ledscan_pkg::HOLD_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            hold_ticks_reg <= pwdata[15:0];
        end
    end

    // ---------------------------------------------------------------- sequencer
    ledscan_pkg::upc_t   upc_reg, upc_next;
    ledscan_pkg::ucode_t uc;
    logic [3:0]          cnt_reg, cnt_next;
    logic [3:0]          digit_reg;
    logic [1:0]          place_reg;
    logic                blink_reg;
    logic                out_free;
    logic                emit_go;

    assign uc       = ledscan_pkg::UCODE[upc_reg];
    assign in_ready = (upc_reg == ledscan_pkg::UPC_IDLE);
    assign out_free = !out_valid || out_ready;
    assign emit_go  = uc.emit && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ledscan_pkg::UPC_IDLE;
            cnt_reg <= 4'd0;
        end
        else
        begin
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            digit_reg <= digit_value;
            place_reg <= digit_position;
            blink_reg <= blinker_on;
        end
    end

    always_comb
    begin
        upc_next = upc_reg;
        cnt_next = cnt_reg;
        priority if (uc.wr_en)
        begin
            if (cnt_reg == uc.cnt_last)
            begin
                upc_next = ledscan_pkg::UPC_IDLE;
                cnt_next = 4'd0;
            end
            else
            begin
                cnt_next = cnt_reg + 4'd1;
            end
        end
        else if (uc.emit)
        begin
            if (out_free)
            begin
                upc_next = ledscan_pkg::UPC_IDLE;
            end
        end
        else if (in_valid)
        begin
            cnt_next = 4'd0;
            unique case (req_type)
                ledscan_pkg::REQ_DIGIT:
                begin
                    if (digit_value <= ledscan_pkg::DIGIT_MAX)
                    begin
                        upc_next = ledscan_pkg::UPC_WR_GLYPH;
                    end
                end
                ledscan_pkg::REQ_BLINK: upc_next = ledscan_pkg::UPC_WR_COLON;
                ledscan_pkg::REQ_SCAN:  upc_next = ledscan_pkg::UPC_SCAN_EMIT;
                default:                upc_next = ledscan_pkg::UPC_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------- frame store
    logic [ledscan_pkg::FRAME_BYTES-1:0] valid_reg;
    logic [ledscan_pkg::FRAME_AW-1:0]    wr_addr;
    logic [7:0]                          wr_data;
    logic [ledscan_pkg::FONT_AW-1:0]     font_idx;
    logic [ledscan_pkg::FRAME_AW-1:0]    rd_addr;
    logic                                rd_en;
    logic [7:0]                          rd_data;
    logic                                rd_valid_reg;
    logic [7:0]                          pix_byte;

    assign font_idx = 7'(digit_reg) * 7'(ledscan_pkg::GLYPH_BYTES) + 7'(cnt_reg);

    always_comb
    begin
        if (uc.wr_colon)
        begin
            wr_addr = ledscan_pkg::BLINK_BASE + 6'(cnt_reg[1:0]);
            wr_data = blink_reg ? ledscan_pkg::COLON_PATTERN[cnt_reg[1:0]] : 8'd0;
        end
        else
        begin
            wr_addr = ledscan_pkg::PLACE_BASE[place_reg] + 6'(cnt_reg);
            wr_data = ledscan_pkg::FONT_ROM[font_idx];
        end
    end

    ledscan_ram #(
        .WIDTH (8),
        .DEPTH (ledscan_pkg::FRAME_BYTES)
    ) u_frame (
        .clk   (clk),
        .we    (uc.wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (uc.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign pix_byte = rd_valid_reg ? rd_data : 8'd0;

    // ---------------------------------------------------------------- scan engine
    ledscan_pkg::phase_t phase_reg, phase_next;
    logic [2:0]          row_reg, row_next;
    logic [1:0]          bank_reg, bank_next;
    logic [4:0]          bit_cnt_reg, bit_cnt_next;
    logic [15:0]         hold_cnt_reg, hold_cnt_next;
    logic [3:0]          pins_reg, pins_next;
    logic                out_valid_reg;
    ledscan_pkg::phase_t eff_phase;
    logic [1:0]          eff_bank;
    logic [4:0]          eff_cnt;
    logic [7:0]          tx_byte;
    logic [2:0]          row_last;

    assign row_last = 3'(ROWS - 1);

    // Pixel bytes of one bank go odd first, then even: base = row*8 + (3-bank)*2.
    assign rd_en   = in_ready;
    assign rd_addr = {row_reg, ~bank_reg, ~bit_cnt_reg[4]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ledscan_pkg::PH_BANK;
            row_reg       <= 3'd0;
            bank_reg      <= 2'd3;
            bit_cnt_reg   <= 5'd0;
            hold_cnt_reg  <= 16'd0;
            pins_reg      <= 4'hf;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_go)
            begin
                phase_reg    <= phase_next;
                row_reg      <= row_next;
                bank_reg     <= bank_next;
                bit_cnt_reg  <= bit_cnt_next;
                hold_cnt_reg <= hold_cnt_next;
                pins_reg     <= pins_next;
            end
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        // An expired hold falls through to the next bank or row select this tick.
        eff_phase = phase_reg;
        eff_bank  = bank_reg;
        eff_cnt   = bit_cnt_reg;
        if (phase_reg == ledscan_pkg::PH_HOLD && hold_cnt_reg >= hold_ticks_reg)
        begin
            eff_cnt = 5'd0;
            if (bank_reg == 2'd0)
            begin
                eff_phase = ledscan_pkg::PH_ROW;
            end
            else
            begin
                eff_phase = ledscan_pkg::PH_BANK;
                eff_bank  = bank_reg - 2'd1;
            end
        end

        phase_next    = eff_phase;
        row_next      = row_reg;
        bank_next     = eff_bank;
        bit_cnt_next  = eff_cnt + 5'd1;
        hold_cnt_next = 16'd0;
        pins_next     = pins_reg;
        tx_byte       = 8'd0;

        unique case (eff_phase)
            ledscan_pkg::PH_PIX:
            begin
                tx_byte                      = pix_byte;
                pins_next[ledscan_pkg::PIN_MOD] = 1'b0;
                pins_next[ledscan_pkg::PIN_STB] = 1'b1;
                if (eff_cnt == 5'd31)
                begin
                    bit_cnt_next = 5'd0;
                    phase_next   = ledscan_pkg::PH_HOLD;
                end
            end
            ledscan_pkg::PH_HOLD:
            begin
                bit_cnt_next  = eff_cnt;
                hold_cnt_next = hold_cnt_reg + 16'd1;
            end
            ledscan_pkg::PH_ROW:
            begin
                tx_byte                      = 8'd1 << row_reg;
                pins_next[ledscan_pkg::PIN_MOD] = 1'b1;
                if (eff_cnt == 5'd15)
                begin
                    bit_cnt_next = 5'd0;
                    phase_next   = ledscan_pkg::PH_LATCH;
                end
            end
            ledscan_pkg::PH_LATCH:
            begin
                pins_next[ledscan_pkg::PIN_STB] = 1'b0;
                pins_next[ledscan_pkg::PIN_MOD] = 1'b0;
                row_next     = (row_reg >= row_last) ? 3'd0 : row_reg + 3'd1;
                bank_next    = 2'd3;
                bit_cnt_next = 5'd0;
                phase_next   = ledscan_pkg::PH_BANK;
            end
            default:
            begin
                // bank select; an undefined phase code restarts here at tick zero
                if (eff_phase != ledscan_pkg::PH_BANK)
                begin
                    eff_cnt = 5'd0;
                end
                tx_byte                      = {6'd0, eff_bank};
                pins_next[ledscan_pkg::PIN_MOD] = 1'b1;
                phase_next   = ledscan_pkg::PH_BANK;
                bit_cnt_next = eff_cnt + 5'd1;
                if (eff_cnt == 5'd15)
                begin
                    bit_cnt_next = 5'd0;
                    phase_next   = ledscan_pkg::PH_PIX;
                end
            end
        endcase

        // serial bit: low half of the bit then high half, LSB first
        if (eff_phase != ledscan_pkg::PH_HOLD && eff_phase != ledscan_pkg::PH_LATCH)
        begin
            pins_next[ledscan_pkg::PIN_DAT] = tx_byte[eff_cnt[3:1]];
            pins_next[ledscan_pkg::PIN_CLK] = eff_cnt[0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign pin_clock  = pins_reg[ledscan_pkg::PIN_CLK];
    assign pin_data   = pins_reg[ledscan_pkg::PIN_DAT];
    assign pin_strobe = pins_reg[ledscan_pkg::PIN_STB];
    assign pin_mode   = pins_reg[ledscan_pkg::PIN_MOD];

`ifndef SYNTHESIS
    // A new pin item only ever comes out of the emit step.
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(upc_reg == ledscan_pkg::UPC_SCAN_EMIT))
        else $error("pin item presented outside the emit step");

    // Select bytes take 16 ticks, so the tick count never reaches bit 4 there.
    a_select_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ledscan_pkg::PH_BANK || phase_reg == ledscan_pkg::PH_ROW)
        |-> !bit_cnt_reg[4])
        else $error("select tick count out of range");

    // Scan state only moves when the pin register can take the new item.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(pins_reg) && $stable(phase_reg))
        else $error("scan advanced while pins stalled");

    // Frame store writes happen only in the draw steps, never while idle.
    a_write_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !uc.wr_en)
        else $error("frame store written while accepting an item");
`endif

endmodule

// File: design/ledscan_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ledscan_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
